[hdl/ffba_pkg.sv]
// Shared types and codes for the first-fit block allocator.
package ffba_pkg;

    localparam int VAL_W = 17;

    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_FREE    = 2'd1,
        FN_QUERY   = 2'd2,
        FN_REALLOC = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NULL      = 2'd1,
        ST_NO_MEM    = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_func       func;
        logic [15:0] req_size;
        logic [15:0] block_addr;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [15:0] result_addr;
        logic [15:0] result_size;
        logic [15:0] copy_length;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_CHK,
        S_REL_N_CHK,
        S_REL_NN_WR,
        S_REL_P_ISSUE,
        S_REL_P_CHK,
        S_REL_PN_WR,
        S_TAKE_CHK,
        S_TAKE_NX_WR,
        S_TAKE_WR_CUR,
        S_TAKE_NEW,
        S_TAKE_WR_LAST,
        S_DONE
    } t_state;

endpackage

[hdl/first_fit_block_allocator.sv]
// First-fit block allocator: request sequencer around the block table memory.
//
// The block list lives in a simple dual-port table memory with a registered
// read port, one entry read per cycle as the list is walked. A reallocate
// that moves walks the list twice, once to find the block and once to take a
// new one, and the sequencer returns to idle before the next request is
// taken. The list walk through the table memory sets the time a request takes.
// One request is worked on at a time; the finished result sits in an output
// register so the next request can be accepted while it waits. Entry valid
// bits are flip-flops cleared by reset, so no clearing pass is needed after
// reset.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int ARENA_BYTES  = 65536,
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int IW = $clog2(MAX_BLOCKS + 1);
    localparam logic [IW-1:0] NIL = IW'(MAX_BLOCKS);
    localparam int USABLE = (ARENA_BYTES < 65536) ? ARENA_BYTES : 65536;
    localparam logic [VAL_W:0] HDR = (VAL_W + 1)'(HEADER_BYTES);
    localparam logic [VAL_W:0] LIMIT = (VAL_W + 1)'(USABLE);

    typedef struct packed {
        logic [VAL_W-1:0] start;
        logic [VAL_W-1:0] size;
        logic             free;
        logic [IW-1:0]    next;
        logic [IW-1:0]    prev;
    } t_entry;

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rd;

    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    t_entry        mem_wdata;

    t_state r_state, n_state;
    logic [MAX_BLOCKS-1:0] r_valid, n_valid;
    logic [IW-1:0] r_head, n_head;
    logic [VAL_W-1:0] r_top, n_top;
    t_func r_func, n_func;
    logic [VAL_W-1:0] r_req, n_req;
    logic [15:0] r_addr, n_addr;
    logic [VAL_W-1:0] r_old, n_old;
    logic r_after_rel, n_after_rel;
    logic [IW-1:0] r_cur_idx, n_cur_idx;
    t_entry r_cur, n_cur;
    logic [IW-1:0] r_last_idx, n_last_idx;
    t_entry r_last, n_last;
    logic [IW-1:0] r_nb_idx, n_nb_idx;
    logic [IW-1:0] r_nx_idx, n_nx_idx;
    t_status r_st, n_st;
    logic [15:0] r_raddr, n_raddr, r_rsize, n_rsize, r_copy, n_copy;
    logic r_o_valid, n_o_valid;
    t_rsp r_o_data, n_o_data;

    logic          spare_ok;
    logic [AW-1:0] spare_idx;

    always_comb begin
        spare_ok  = 1'b0;
        spare_idx = '0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                spare_ok  = 1'b1;
                spare_idx = AW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_head    <= NIL;
            r_top     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_head    <= n_head;
            r_top     <= n_top;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_req       <= n_req;
        r_addr      <= n_addr;
        r_old       <= n_old;
        r_after_rel <= n_after_rel;
        r_cur_idx   <= n_cur_idx;
        r_cur       <= n_cur;
        r_last_idx  <= n_last_idx;
        r_last      <= n_last;
        r_nb_idx    <= n_nb_idx;
        r_nx_idx    <= n_nx_idx;
        r_st        <= n_st;
        r_raddr     <= n_raddr;
        r_rsize     <= n_rsize;
        r_copy      <= n_copy;
        r_o_data    <= n_o_data;
    end

    logic [VAL_W:0] sum_a, sum_b, need;
    logic [VAL_W-1:0] min_sz;
    t_entry w_ent;

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_head      = r_head;
        n_top       = r_top;
        n_func      = r_func;
        n_req       = r_req;
        n_addr      = r_addr;
        n_old       = r_old;
        n_after_rel = r_after_rel;
        n_cur_idx   = r_cur_idx;
        n_cur       = r_cur;
        n_last_idx  = r_last_idx;
        n_last      = r_last;
        n_nb_idx    = r_nb_idx;
        n_nx_idx    = r_nx_idx;
        n_st        = r_st;
        n_raddr     = r_raddr;
        n_rsize     = r_rsize;
        n_copy      = r_copy;
        n_o_data    = r_o_data;
        n_o_valid   = r_o_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = r_rd;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        w_ent       = r_rd;
        sum_a       = '0;
        sum_b       = '0;
        need        = {1'b0, r_top} + HDR + {1'b0, r_req};
        min_sz      = (r_old < r_req) ? r_old : r_req;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func      = i_in_data.func;
                    n_req       = {1'b0, i_in_data.req_size};
                    n_addr      = i_in_data.block_addr;
                    n_old       = '0;
                    n_st        = ST_OK;
                    n_raddr     = '0;
                    n_rsize     = '0;
                    n_copy      = '0;
                    n_after_rel = 1'b0;
                    n_cur_idx   = r_head;
                    n_last_idx  = NIL;
                    mem_raddr   = r_head;
                    if ((i_in_data.func == FN_ALLOC || i_in_data.block_addr == '0) &&
                        (i_in_data.func == FN_ALLOC || i_in_data.func == FN_REALLOC) &&
                        i_in_data.req_size != '0) begin
                        if (r_head == NIL) begin
                            n_state = S_TAKE_NEW;
                        end else begin
                            mem_re  = 1'b1;
                            n_state = S_TAKE_CHK;
                        end
                    end else if (i_in_data.func == FN_ALLOC || i_in_data.block_addr == '0) begin
                        n_st    = ST_NULL;
                        n_state = S_DONE;
                    end else if (r_head == NIL) begin
                        n_st    = ST_NOT_FOUND;
                        n_state = S_DONE;
                    end else begin
                        mem_re  = 1'b1;
                        n_state = S_FIND_CHK;
                    end
                end
            end

            S_FIND_CHK: begin
                if (r_rd.start == {1'b0, r_addr}) begin
                    n_cur      = r_rd;
                    n_cur.free = 1'b1;
                    case (r_func)
                        FN_QUERY: begin
                            n_rsize = r_rd.size[15:0];
                            n_state = S_DONE;
                        end
                        FN_FREE: begin
                            n_state = S_REL_P_ISSUE;
                        end
                        default: begin
                            n_old   = r_rd.size;
                            n_rsize = r_rd.size[15:0];
                            if (r_req == '0) begin
                                n_st    = ST_NULL;
                                n_state = S_REL_P_ISSUE;
                            end else if (r_rd.size == r_req) begin
                                n_raddr = r_addr;
                                n_copy  = r_req[15:0];
                                n_state = S_DONE;
                            end else begin
                                n_after_rel = 1'b1;
                                n_state     = S_REL_P_ISSUE;
                            end
                        end
                    endcase
                    if (n_state == S_REL_P_ISSUE && r_rd.next != NIL) begin
                        mem_re    = 1'b1;
                        mem_raddr = r_rd.next;
                        n_state   = S_REL_N_CHK;
                    end
                end else if (r_rd.next == NIL) begin
                    n_st    = ST_NOT_FOUND;
                    n_state = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_rd.next;
                    n_cur_idx = r_rd.next;
                end
            end

            S_REL_N_CHK: begin
                sum_a   = {1'b0, r_cur.start} + {1'b0, r_cur.size} + HDR;
                n_state = S_REL_P_ISSUE;
                if (r_rd.free && sum_a == {1'b0, r_rd.start}) begin
                    sum_b      = {1'b0, r_cur.size} + {1'b0, r_rd.size} + HDR;
                    n_cur.size = sum_b[VAL_W-1:0];
                    n_cur.next = r_rd.next;
                    n_valid[r_cur.next[AW-1:0]] = 1'b0;
                    if (r_rd.next != NIL) begin
                        mem_re    = 1'b1;
                        mem_raddr = r_rd.next;
                        n_nb_idx  = r_rd.next;
                        n_state   = S_REL_NN_WR;
                    end
                end
            end

            S_REL_NN_WR: begin
                w_ent      = r_rd;
                w_ent.prev = r_cur_idx;
                mem_we     = 1'b1;
                mem_waddr  = r_nb_idx;
                mem_wdata  = w_ent;
                n_state    = S_REL_P_ISSUE;
            end

            S_REL_P_ISSUE: begin
                if (r_cur.prev != NIL) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_cur.prev;
                    n_nb_idx  = r_cur.prev;
                    n_state   = S_REL_P_CHK;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cur_idx;
                    mem_wdata = r_cur;
                    n_state   = r_after_rel ? S_TAKE_CHK : S_DONE;
                end
            end

            S_REL_P_CHK: begin
                sum_a   = {1'b0, r_rd.start} + {1'b0, r_rd.size} + HDR;
                n_state = r_after_rel ? S_TAKE_CHK : S_DONE;
                if (r_rd.free && sum_a == {1'b0, r_cur.start}) begin
                    sum_b      = {1'b0, r_rd.size} + {1'b0, r_cur.size} + HDR;
                    w_ent      = r_rd;
                    w_ent.size = sum_b[VAL_W-1:0];
                    w_ent.next = r_cur.next;
                    mem_we     = 1'b1;
                    mem_waddr  = r_nb_idx;
                    mem_wdata  = w_ent;
                    n_valid[r_cur_idx[AW-1:0]] = 1'b0;
                    if (r_cur.next != NIL) begin
                        mem_re    = 1'b1;
                        mem_raddr = r_cur.next;
                        n_state   = S_REL_PN_WR;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cur_idx;
                    mem_wdata = r_cur;
                end
            end

            S_REL_PN_WR: begin
                w_ent      = r_rd;
                w_ent.prev = r_nb_idx;
                mem_we     = 1'b1;
                mem_waddr  = r_cur.next;
                mem_wdata  = w_ent;
                n_state    = r_after_rel ? S_TAKE_CHK : S_DONE;
            end

            S_TAKE_CHK: begin
                if (r_after_rel) begin
                    n_after_rel = 1'b0;
                    n_cur_idx   = r_head;
                    n_last_idx  = NIL;
                    mem_raddr   = r_head;
                    if (r_head == NIL) begin
                        n_state = S_TAKE_NEW;
                    end else begin
                        mem_re  = 1'b1;
                        n_state = S_TAKE_CHK;
                    end
                end else if (r_rd.free && r_rd.size >= r_req) begin
                    sum_a      = {1'b0, r_req} + HDR;
                    n_cur      = r_rd;
                    n_cur.free = 1'b0;
                    n_st       = ST_OK;
                    n_raddr    = r_rd.start[15:0];
                    if (r_func == FN_REALLOC) begin
                        n_copy = min_sz[15:0];
                    end
                    n_state = S_TAKE_WR_CUR;
                    if ({1'b0, r_rd.size} >= sum_a && spare_ok) begin
                        sum_b         = {1'b0, r_rd.start} + sum_a;
                        w_ent.start   = sum_b[VAL_W-1:0];
                        sum_b         = {1'b0, r_rd.size} - sum_a;
                        w_ent.size    = sum_b[VAL_W-1:0];
                        w_ent.free    = 1'b1;
                        w_ent.prev    = r_cur_idx;
                        w_ent.next    = r_rd.next;
                        mem_we        = 1'b1;
                        mem_waddr     = IW'(spare_idx);
                        mem_wdata     = w_ent;
                        n_valid[spare_idx] = 1'b1;
                        n_cur.next    = IW'(spare_idx);
                        n_cur.size    = r_req;
                        n_nb_idx      = IW'(spare_idx);
                        if (r_rd.next != NIL) begin
                            mem_re    = 1'b1;
                            mem_raddr = r_rd.next;
                            n_nx_idx  = r_rd.next;
                            n_state   = S_TAKE_NX_WR;
                        end
                    end
                end else begin
                    n_last     = r_rd;
                    n_last_idx = r_cur_idx;
                    if (r_rd.next == NIL) begin
                        n_state = S_TAKE_NEW;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_rd.next;
                        n_cur_idx = r_rd.next;
                    end
                end
            end

            S_TAKE_NX_WR: begin
                w_ent      = r_rd;
                w_ent.prev = r_nb_idx;
                mem_we     = 1'b1;
                mem_waddr  = r_nx_idx;
                mem_wdata  = w_ent;
                n_state    = S_TAKE_WR_CUR;
            end

            S_TAKE_WR_CUR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cur_idx;
                mem_wdata = r_cur;
                n_state   = S_DONE;
            end

            S_TAKE_NEW: begin
                if (!spare_ok || need > LIMIT) begin
                    n_st    = ST_NO_MEM;
                    n_raddr = '0;
                    n_state = S_DONE;
                end else begin
                    sum_a       = {1'b0, r_top} + HDR;
                    w_ent.start = sum_a[VAL_W-1:0];
                    w_ent.size  = r_req;
                    w_ent.free  = 1'b0;
                    w_ent.next  = NIL;
                    w_ent.prev  = r_last_idx;
                    mem_we      = 1'b1;
                    mem_waddr   = IW'(spare_idx);
                    mem_wdata   = w_ent;
                    n_valid[spare_idx] = 1'b1;
                    n_top       = need[VAL_W-1:0];
                    n_st        = ST_OK;
                    n_raddr     = sum_a[15:0];
                    if (r_func == FN_REALLOC) begin
                        n_copy = min_sz[15:0];
                    end
                    if (r_last_idx != NIL) begin
                        n_last.next = IW'(spare_idx);
                        n_state     = S_TAKE_WR_LAST;
                    end else begin
                        n_head  = IW'(spare_idx);
                        n_state = S_DONE;
                    end
                end
            end

            S_TAKE_WR_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = r_last_idx;
                mem_wdata = r_last;
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid            = 1'b1;
                    n_o_data.status      = r_st;
                    n_o_data.result_addr = r_raddr;
                    n_o_data.result_size = r_rsize;
                    n_o_data.copy_length = r_copy;
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule

[bench/ffba_checker.sv]
// Transaction checker for the first-fit block allocator: it predicts each response and compares.
module ffba_checker
    import ffba_pkg::*;
#(
    parameter int ARENA_BYTES  = 65536,
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_req i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_rsp i_out_data,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NIL = MAX_BLOCKS;

    bit blk_used [MAX_BLOCKS];
    int blk_start [MAX_BLOCKS];
    int blk_size [MAX_BLOCKS];
    bit blk_free [MAX_BLOCKS];
    int blk_next [MAX_BLOCKS];
    int blk_prev [MAX_BLOCKS];
    int head_blk;
    int heap_top;
    t_rsp expected_rsps [$];

    function automatic int unused_slot();
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (!blk_used[i]) return i;
        end
        return NIL;
    endfunction

    function automatic int lookup_block(int addr);
        int cur;
        int steps;
        cur = head_blk;
        steps = 0;
        while (cur < NIL && steps < NIL) begin
            if (blk_start[cur] == addr) return cur;
            cur = blk_next[cur];
            steps++;
        end
        return NIL;
    endfunction

    function automatic t_status grab_block(int req, output int addr);
        int cur;
        int last;
        int steps;
        int s;
        int nx;
        int need;
        int usable;
        cur = head_blk;
        last = NIL;
        steps = 0;
        addr = 0;
        usable = (ARENA_BYTES < 65536) ? ARENA_BYTES : 65536;
        while (cur < NIL && steps < NIL) begin
            if (blk_free[cur] && blk_size[cur] >= req) break;
            last = cur;
            cur = blk_next[cur];
            steps++;
        end
        if (cur < NIL && steps < NIL) begin
            if (blk_size[cur] >= req + HEADER_BYTES) begin
                s = unused_slot();
                if (s < NIL) begin
                    nx = blk_next[cur];
                    blk_used[s] = 1;
                    blk_start[s] = blk_start[cur] + req + HEADER_BYTES;
                    blk_size[s] = blk_size[cur] - req - HEADER_BYTES;
                    blk_free[s] = 1;
                    blk_prev[s] = cur;
                    blk_next[s] = nx;
                    if (nx < NIL) blk_prev[nx] = s;
                    blk_next[cur] = s;
                    blk_size[cur] = req;
                end
            end
            blk_free[cur] = 0;
            addr = blk_start[cur];
            return ST_OK;
        end
        s = unused_slot();
        need = heap_top + HEADER_BYTES + req;
        if (s >= NIL || need > usable) return ST_NO_MEM;
        blk_used[s] = 1;
        blk_start[s] = heap_top + HEADER_BYTES;
        blk_size[s] = req;
        blk_free[s] = 0;
        blk_next[s] = NIL;
        blk_prev[s] = last;
        if (last < NIL) blk_next[last] = s;
        else head_blk = s;
        heap_top = need;
        addr = blk_start[s];
        return ST_OK;
    endfunction

    function automatic void give_back(int t);
        int n;
        int nn;
        int p;
        blk_free[t] = 1;
        n = blk_next[t];
        if (n < NIL && blk_free[n] &&
            blk_start[t] + blk_size[t] + HEADER_BYTES == blk_start[n]) begin
            nn = blk_next[n];
            blk_size[t] += blk_size[n] + HEADER_BYTES;
            if (nn < NIL) blk_prev[nn] = t;
            blk_next[t] = nn;
            blk_used[n] = 0;
        end
        p = blk_prev[t];
        if (p < NIL && blk_free[p] &&
            blk_start[p] + blk_size[p] + HEADER_BYTES == blk_start[t]) begin
            n = blk_next[t];
            blk_size[p] += blk_size[t] + HEADER_BYTES;
            if (n < NIL) blk_prev[n] = p;
            blk_next[p] = n;
            blk_used[t] = 0;
        end
    endfunction

    function automatic t_rsp serve_request(t_req rq);
        t_rsp r;
        int req;
        int addr;
        int raddr;
        int idx;
        int old;
        req = rq.req_size;
        addr = rq.block_addr;
        raddr = 0;
        r = '0;
        r.status = ST_OK;
        if (rq.func == FN_ALLOC) begin
            if (req == 0) r.status = ST_NULL;
            else r.status = grab_block(req, raddr);
        end else if (rq.func == FN_FREE || rq.func == FN_QUERY) begin
            if (addr == 0) begin
                r.status = ST_NULL;
            end else begin
                idx = lookup_block(addr);
                if (idx >= NIL) r.status = ST_NOT_FOUND;
                else if (rq.func == FN_FREE) give_back(idx);
                else r.result_size = blk_size[idx][15:0];
            end
        end else if (addr == 0) begin
            if (req == 0) r.status = ST_NULL;
            else r.status = grab_block(req, raddr);
        end else begin
            idx = lookup_block(addr);
            if (idx >= NIL) begin
                r.status = ST_NOT_FOUND;
            end else begin
                old = blk_size[idx];
                r.result_size = old[15:0];
                if (req == 0) begin
                    give_back(idx);
                    r.status = ST_NULL;
                end else if (old == req) begin
                    raddr = addr;
                    r.copy_length = req[15:0];
                end else begin
                    give_back(idx);
                    r.status = grab_block(req, raddr);
                    if (r.status == ST_OK) r.copy_length = 16'((old < req) ? old : req);
                end
            end
        end
        r.result_addr = raddr[15:0];
        return r;
    endfunction

    initial begin
        for (int i = 0; i < MAX_BLOCKS; i++) blk_used[i] = 0;
        head_blk = NIL;
        heap_top = 0;
        o_errors = 0;
    end

    assign o_pending = expected_rsps.size();

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            expected_rsps.push_back(serve_request(i_in_data));
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_rsps.size() == 0) begin
                $error("Unexpected response transaction: %p", i_out_data);
                o_errors++;
            end else begin
                exp_rsp = expected_rsps.pop_front();
                if (i_out_data.status !== exp_rsp.status) begin
                    $error("status: expected %0d, got %0d", exp_rsp.status,
                           i_out_data.status);
                    o_errors++;
                end
                if (i_out_data.result_addr !== exp_rsp.result_addr) begin
                    $error("result_addr: expected %0d, got %0d", exp_rsp.result_addr,
                           i_out_data.result_addr);
                    o_errors++;
                end
                if (i_out_data.result_size !== exp_rsp.result_size) begin
                    $error("result_size: expected %0d, got %0d", exp_rsp.result_size,
                           i_out_data.result_size);
                    o_errors++;
                end
                if (i_out_data.copy_length !== exp_rsp.copy_length) begin
                    $error("copy_length: expected %0d, got %0d", exp_rsp.copy_length,
                           i_out_data.copy_length);
                    o_errors++;
                end
            end
        end
    end
endmodule

[bench/first_fit_block_allocator_tb.sv]
// Top of the first-fit block allocator testbench: clock, reset, stimulus and verdict.
module first_fit_block_allocator_tb;
    import ffba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_stall;
    t_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 0;
    t_rsp o_out_data;
    int   fail_count;
    int   pending_count;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_off = 0;
    logic [15:0] known_addrs [$];

    first_fit_block_allocator u_dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_in_data,
        .o_out_valid, .i_out_stall, .o_out_data
    );

    ffba_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_data(o_out_data),
        .o_errors(fail_count), .o_pending(pending_count)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= hold_off || ($urandom_range(99) < stall_pct);
        if (o_out_valid && !i_out_stall && o_out_data.status == ST_OK &&
            o_out_data.result_addr != 0) begin
            known_addrs.push_back(o_out_data.result_addr);
            if (known_addrs.size() > 80) void'(known_addrs.pop_front());
        end
    end

    task automatic send_request(t_func fn, logic [15:0] size, logic [15:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data <= '{func: fn, req_size: size, block_addr: addr};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 16'($urandom_range(200, 1));
        if (r < 85) return 16'($urandom_range(3000, 1));
        if (r < 92) return 16'd0;
        return 16'($urandom_range(65535));
    endfunction

    function automatic logic [15:0] pick_addr();
        int r;
        r = $urandom_range(99);
        if (r < 80 && known_addrs.size() > 0)
            return known_addrs[$urandom_range(known_addrs.size() - 1)];
        if (r < 90) return 16'd0;
        return 16'($urandom_range(65535));
    endfunction

    initial begin
        int r;
        t_func fn;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_request(FN_ALLOC, 16'd0, 16'd0);
        send_request(FN_ALLOC, 16'd1, 16'd0);
        send_request(FN_ALLOC, 16'hFFFF, 16'hFFFF);
        send_request(FN_QUERY, 16'd0, 16'd0);
        send_request(FN_FREE, 16'd0, 16'd0);
        send_request(FN_FREE, 16'd0, 16'd5);
        send_request(FN_REALLOC, 16'd0, 16'd0);
        send_request(FN_REALLOC, 16'd100, 16'd0);
        send_request(FN_QUERY, 16'd0, 16'd16);
        send_request(FN_REALLOC, 16'd1, 16'd16);
        send_request(FN_ALLOC, 16'd48, 16'd0);
        send_request(FN_FREE, 16'd0, 16'd149);
        send_request(FN_ALLOC, 16'd32, 16'd0);
        send_request(FN_FREE, 16'd0, 16'd149);
        send_request(FN_FREE, 16'd0, 16'd149);
        send_request(FN_REALLOC, 16'd200, 16'd33);
        send_request(FN_REALLOC, 16'd0, 16'd16);
        send_request(FN_QUERY, 16'd0, 16'hFFFF);
        send_request(FN_REALLOC, 16'd10, 16'd7);
        send_request(FN_ALLOC, 16'd65000, 16'd0);
        send_request(FN_ALLOC, 16'hAAAA, 16'h5555);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1) ? 81 : (phase == 3) ? 6 : 0;
            stall_pct = (phase == 2) ? 81 : (phase == 3) ? 6 : 0;
            for (int n = 0; n < 270; n++) begin
                r = $urandom_range(99);
                fn = (r < 38) ? FN_ALLOC : (r < 66) ? FN_FREE :
                     (r < 80) ? FN_QUERY : FN_REALLOC;
                send_request(fn, pick_size(), pick_addr());
            end
        end
        i_in_valid <= 0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        repeat (200) @(posedge i_clk);
        hold_off = 1;
        repeat (400) @(posedge i_clk);
        hold_off = 0;
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[filelist.f]
hdl/ffba_pkg.sv
hdl/first_fit_block_allocator.sv
bench/ffba_checker.sv
bench/first_fit_block_allocator_tb.sv
